// ----- rtl/grpd_pkg.sv -----
// Package for the gated ratio peak detector.
// Holds widths, configuration register indexes and the shared structs.
// No dependencies.
package grpd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 13;
    localparam int COUNT_W  = 13;
    localparam int RATIO_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIN_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO      = 2'd2;

    localparam logic [INDEX_W-1:0]  GATE_MIN       = 13'd2;
    localparam logic [INDEX_W-1:0]  GATE_END_RST   = 13'd8191;
    localparam logic [RATIO_W-1:0]  RATIO_RST      = 16'd512;
    localparam logic [COUNT_W-1:0]  COUNT_MAX      = 13'd8191;
    localparam logic [SAMPLE_W-1:0] MIN_RST        = 16'hFFFF;

    typedef struct packed {
        logic [INDEX_W-1:0] gate_start;
        logic [INDEX_W-1:0] gate_end;
        logic [RATIO_W-1:0] ratio;
    } t_cfg;

    typedef struct packed {
        logic                peak;
        logic [INDEX_W-1:0]  center;
        logic [SAMPLE_W-1:0] amp;
        logic [SAMPLE_W-1:0] new_min;
    } t_test;

endpackage

// ----- rtl/grpd_peak_test.sv -----
// Peak test on the centre of the five-sample window.
// Gate check, neighbor compares, running minimum and ratio test.
// Depends on grpd_pkg.
module grpd_peak_test (
    input  grpd_pkg::t_cfg                  i_cfg,
    input  logic [grpd_pkg::SAMPLE_W-1:0]   i_win [grpd_pkg::WIN_DEPTH],
    input  logic [grpd_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [grpd_pkg::INDEX_W-1:0]    i_index,
    input  logic [grpd_pkg::SAMPLE_W-1:0]   i_min,
    output grpd_pkg::t_test                 o_test
);

    logic                                         have_center;
    logic [grpd_pkg::INDEX_W-1:0]                 center;
    logic [grpd_pkg::INDEX_W-1:0]                 lo;
    logic [grpd_pkg::SAMPLE_W-1:0]                amp;
    logic [grpd_pkg::SAMPLE_W-1:0]                min_upd;
    logic [grpd_pkg::SAMPLE_W+grpd_pkg::RATIO_W-1:0] lhs;
    logic [grpd_pkg::SAMPLE_W+grpd_pkg::RATIO_W-1:0] rhs;
    logic                                         in_gate;
    logic                                         is_max;

    assign have_center = (i_index >= grpd_pkg::GATE_MIN);
    assign center      = i_index - grpd_pkg::GATE_MIN;
    assign amp         = i_win[1];
    assign lo          = (i_cfg.gate_start < grpd_pkg::GATE_MIN) ? grpd_pkg::GATE_MIN
                                                                 : i_cfg.gate_start;
    assign min_upd     = (have_center && (amp < i_min)) ? amp : i_min;

    // centre * 256 against ratio (Q8.8) * minimum
    assign lhs = {8'd0, amp, 8'd0};
    assign rhs = {{grpd_pkg::SAMPLE_W{1'b0}}, i_cfg.ratio} *
                 {{grpd_pkg::RATIO_W{1'b0}}, min_upd};

    assign in_gate = (center >= lo) && (center < i_cfg.gate_end);
    assign is_max  = (amp > i_win[3]) && (amp > i_sample) &&
                     (amp >= i_win[0]) && (amp >= i_win[2]);

    assign o_test.peak    = have_center && in_gate && is_max && (lhs > rhs);
    assign o_test.center  = center;
    assign o_test.amp     = amp;
    assign o_test.new_min = min_upd;

endmodule

// ----- rtl/gated_ratio_peak_detector.sv -----
// Gated ratio peak detector top level.
// Depends on grpd_pkg and grpd_peak_test.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready): one echo sample per transaction,
//   i_last marks the final sample of a frame.
// - Output channel (o_out_valid / i_out_ready): one result transaction when
//   the centre sample two back is a peak inside the gate, when the sample
//   is the frame's last, or both. Other samples produce nothing.
// - Config port: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 gate_start, 1 gate_end, 2 ratio_threshold) in the same cycle.
// Timing: the result is registered and appears in the cycle after the sample is accepted.
// Throughput is one sample per cycle while the output is not stalled; the whole test (compares and one
// 16x16 multiply) sits between the state registers and the result register.
// Stall: o_in_ready is high while the result register is empty or being
// taken, so a stalled receiver holds off input only while a result waits.
// Reset: synchronous, active low; clears the window, sample index, count,
// sets the running minimum to all ones and the registers to 2, 8191, 512.
// After a last sample the frame state returns to those values.
module gated_ratio_peak_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [grpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [grpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [grpd_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_peak_valid,
    output logic [grpd_pkg::INDEX_W-1:0]    o_peak_index,
    output logic [grpd_pkg::SAMPLE_W-1:0]   o_peak_amplitude,
    output logic                            o_frame_done,
    output logic [grpd_pkg::COUNT_W-1:0]    o_peak_count
);

    grpd_pkg::t_cfg                  r_cfg;
    logic [grpd_pkg::SAMPLE_W-1:0]   r_win [grpd_pkg::WIN_DEPTH];
    logic [grpd_pkg::INDEX_W-1:0]    r_index;
    logic [grpd_pkg::SAMPLE_W-1:0]   r_min;
    logic [grpd_pkg::COUNT_W-1:0]    r_count;
    logic                            r_out_valid;
    logic                            r_peak_valid;
    logic [grpd_pkg::INDEX_W-1:0]    r_peak_index;
    logic [grpd_pkg::SAMPLE_W-1:0]   r_peak_amp;
    logic                            r_frame_done;
    logic [grpd_pkg::COUNT_W-1:0]    r_peak_count;

    grpd_pkg::t_test                 test;
    logic                            accept;
    logic                            emit;
    logic [grpd_pkg::COUNT_W-1:0]    n_count;

    grpd_peak_test u_test (
        .i_cfg    (r_cfg),
        .i_win    (r_win),
        .i_sample (i_sample),
        .i_index  (r_index),
        .i_min    (r_min),
        .o_test   (test)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign emit       = test.peak || i_last;
    assign n_count    = (test.peak && (r_count != grpd_pkg::COUNT_MAX)) ? r_count + 1'b1
                                                                        : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_start <= grpd_pkg::GATE_MIN;
            r_cfg.gate_end   <= grpd_pkg::GATE_END_RST;
            r_cfg.ratio      <= grpd_pkg::RATIO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                grpd_pkg::CFG_GATE_START: begin
                    r_cfg.gate_start <= i_cfg_data[grpd_pkg::INDEX_W-1:0];
                end
                grpd_pkg::CFG_GATE_END: begin
                    r_cfg.gate_end <= i_cfg_data[grpd_pkg::INDEX_W-1:0];
                end
                grpd_pkg::CFG_RATIO: begin
                    r_cfg.ratio <= i_cfg_data[grpd_pkg::RATIO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < grpd_pkg::WIN_DEPTH; k++) begin
                r_win[k] <= '0;
            end
            r_index <= '0;
            r_min   <= grpd_pkg::MIN_RST;
            r_count <= '0;
        end else if (accept) begin
            if (i_last) begin
                for (int k = 0; k < grpd_pkg::WIN_DEPTH; k++) begin
                    r_win[k] <= '0;
                end
                r_index <= '0;
                r_min   <= grpd_pkg::MIN_RST;
                r_count <= '0;
            end else begin
                r_win[3] <= r_win[2];
                r_win[2] <= r_win[1];
                r_win[1] <= r_win[0];
                r_win[0] <= i_sample;
                r_index  <= r_index + 1'b1;  // wraps at the frame limit
                r_min    <= test.new_min;
                r_count  <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_peak_valid <= test.peak;
            r_peak_index <= test.peak ? test.center : '0;
            r_peak_amp   <= test.peak ? test.amp : '0;
            r_frame_done <= i_last;
            r_peak_count <= n_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_peak_valid     = r_peak_valid;
    assign o_peak_index     = r_peak_index;
    assign o_peak_amplitude = r_peak_amp;
    assign o_frame_done     = r_frame_done;
    assign o_peak_count     = r_peak_count;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for gated_ratio_peak_detector: random and directed frames.
// A scoreboard class predicts every peak/frame report and checks each one as it arrives.
// Depends on grpd_pkg and the detector RTL.
module testbench;

    typedef struct packed {
        logic                          peak_valid;
        logic [grpd_pkg::INDEX_W-1:0]  peak_index;
        logic [grpd_pkg::SAMPLE_W-1:0] amplitude;
        logic                          frame_done;
        logic [grpd_pkg::COUNT_W-1:0]  count;
    } t_peak_report;

    class peak_scoreboard;
        logic [grpd_pkg::INDEX_W-1:0]  cfg_start;
        logic [grpd_pkg::INDEX_W-1:0]  cfg_end;
        logic [grpd_pkg::RATIO_W-1:0]  cfg_ratio;
        logic [grpd_pkg::SAMPLE_W-1:0] taps [grpd_pkg::WIN_DEPTH];
        logic [grpd_pkg::INDEX_W-1:0]  next_idx;
        logic [grpd_pkg::SAMPLE_W-1:0] floor_amp;
        logic [grpd_pkg::COUNT_W-1:0]  peaks_seen;
        t_peak_report                  expected_reports[$];
        int                            errors;

        function new();
            cfg_start = grpd_pkg::GATE_MIN;
            cfg_end   = grpd_pkg::GATE_END_RST;
            cfg_ratio = grpd_pkg::RATIO_RST;
            errors    = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            foreach (taps[k]) taps[k] = '0;
            next_idx   = '0;
            floor_amp  = grpd_pkg::MIN_RST;
            peaks_seen = '0;
        endfunction

        function void set_register(logic [grpd_pkg::CFG_IDX_W-1:0] idx,
                                   logic [grpd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                grpd_pkg::CFG_GATE_START: cfg_start = data[grpd_pkg::INDEX_W-1:0];
                grpd_pkg::CFG_GATE_END:   cfg_end   = data[grpd_pkg::INDEX_W-1:0];
                grpd_pkg::CFG_RATIO:      cfg_ratio = data[grpd_pkg::RATIO_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted input transaction
        function void note_sample(logic [grpd_pkg::SAMPLE_W-1:0] value, logic is_last);
            logic [grpd_pkg::INDEX_W-1:0]  lo;
            logic [grpd_pkg::INDEX_W-1:0]  centre;
            logic [grpd_pkg::SAMPLE_W-1:0] amp;
            logic [31:0]                   scaled_amp;
            logic [31:0]                   scaled_floor;
            logic                          hit;
            t_peak_report                  rep;
            hit    = 1'b0;
            centre = '0;
            amp    = '0;
            lo     = (cfg_start < grpd_pkg::GATE_MIN) ? grpd_pkg::GATE_MIN : cfg_start;
            if (next_idx >= grpd_pkg::GATE_MIN) begin
                centre = next_idx - grpd_pkg::GATE_MIN;
                amp    = taps[1];
                if (amp < floor_amp)
                    floor_amp = amp;
                scaled_amp   = {8'd0, amp, 8'd0};
                scaled_floor = {16'd0, cfg_ratio} * {16'd0, floor_amp};
                hit = (centre >= lo) && (centre < cfg_end) &&
                      (amp > taps[3]) && (amp > value) &&
                      (amp >= taps[0]) && (amp >= taps[2]) &&
                      (scaled_amp > scaled_floor);
            end
            taps[3]  = taps[2];
            taps[2]  = taps[1];
            taps[1]  = taps[0];
            taps[0]  = value;
            next_idx = next_idx + 1'b1;
            if (hit && peaks_seen != grpd_pkg::COUNT_MAX)
                peaks_seen = peaks_seen + 1'b1;
            if (hit || is_last) begin
                rep.peak_valid = hit;
                rep.peak_index = hit ? centre : '0;
                rep.amplitude  = hit ? amp : '0;
                rep.frame_done = is_last;
                rep.count      = peaks_seen;
                expected_reports.push_back(rep);
            end
            if (is_last)
                clear_frame();
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
                errors++;
            end
        endfunction

        // one accepted output transaction
        function void check_report(t_peak_report got);
            t_peak_report want;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none actual index %0d amp %0d",
                         $time, got.peak_index, got.amplitude);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("peak_valid", 32'(want.peak_valid), 32'(got.peak_valid));
            compare_field("peak_index", 32'(want.peak_index), 32'(got.peak_index));
            compare_field("peak_amplitude", 32'(want.amplitude), 32'(got.amplitude));
            compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
            compare_field("peak_count", 32'(want.count), 32'(got.count));
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [grpd_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [grpd_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [grpd_pkg::SAMPLE_W-1:0]   i_sample;
    logic                            i_last;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic                            o_peak_valid;
    logic [grpd_pkg::INDEX_W-1:0]    o_peak_index;
    logic [grpd_pkg::SAMPLE_W-1:0]   o_peak_amplitude;
    logic                            o_frame_done;
    logic [grpd_pkg::COUNT_W-1:0]    o_peak_count;

    peak_scoreboard sb = new();
    int send_idle_pct = 20;
    int recv_idle_pct = 65;

    gated_ratio_peak_detector dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample         (i_sample),
        .i_last           (i_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_peak_valid     (o_peak_valid),
        .o_peak_index     (o_peak_index),
        .o_peak_amplitude (o_peak_amplitude),
        .o_frame_done     (o_frame_done),
        .o_peak_count     (o_peak_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_report({o_peak_valid, o_peak_index, o_peak_amplitude,
                             o_frame_done, o_peak_count});
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_sample(input logic [grpd_pkg::SAMPLE_W-1:0] value,
                               input logic is_last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= value;
        i_last     <= is_last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(value, is_last);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [grpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [grpd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
    endtask

    task automatic program_gate(input logic [15:0] start_v, input logic [15:0] end_v,
                                input logic [15:0] ratio_v);
        settle();
        write_reg(grpd_pkg::CFG_GATE_START, start_v);
        write_reg(grpd_pkg::CFG_GATE_END, end_v);
        write_reg(grpd_pkg::CFG_RATIO, ratio_v);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_frames(input int n_items);
        int sent;
        int len;
        int style;
        int pick;
        int k;
        logic [grpd_pkg::SAMPLE_W-1:0] base;
        logic [grpd_pkg::SAMPLE_W-1:0] value;
        sent = 0;
        while (sent < n_items) begin
            pick  = $urandom_range(99);
            len   = (pick < 10) ? $urandom_range(1, 3) :
                    (pick < 85) ? $urandom_range(4, 48) : $urandom_range(49, 200);
            if (len > n_items - sent)
                len = n_items - sent;
            style = $urandom_range(2);
            base  = 16'($urandom_range(2000));
            for (k = 0; k < len; k++) begin
                case (style)
                    0: value = 16'($urandom);
                    1: value = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                                         : 16'(base + $urandom_range(15));
                    default: value = 16'($urandom_range(3) * 1000);
                endcase
                send_sample(value, k == len - 1);
            end
            sent += len;
        end
    endtask

    localparam int DIRECTED_N = 24;
    logic [grpd_pkg::SAMPLE_W-1:0] directed_vals [DIRECTED_N] = '{
        16'd1234,
        16'd0, 16'd65535,
        16'd10, 16'd10, 16'd40, 16'd20, 16'd10, 16'd5, 16'd80, 16'd80, 16'd5,
        16'd0, 16'd65535, 16'd0, 16'd0, 16'd30, 16'd9, 16'd30, 16'd9, 16'd5,
        16'd500, 16'd3, 16'd2
    };
    logic directed_last [DIRECTED_N] = '{
        1'b1,
        1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b1
    };

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= grpd_pkg::CFG_GATE_START;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_sample    <= '0;
        i_last      <= 1'b0;
        i_out_ready <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIRECTED_N; k++)
            send_sample(directed_vals[k], directed_last[k]);

        program_gate(16'h0000, 16'hFFFF, 16'd0);
        random_frames(125);
        program_gate(16'hFFFF, 16'h0000, 16'hFFFF);
        random_frames(125);

        send_idle_pct = 65;
        recv_idle_pct = 20;
        program_gate(16'd1, 16'd30, 16'd256);
        random_frames(125);
        program_gate(16'($urandom_range(20)), 16'($urandom_range(10, 150)), 16'($urandom));
        random_frames(125);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_gate(16'd3, 16'h1FFF, 16'hFFFF);
        random_frames(125);
        program_gate(16'($urandom), 16'($urandom), 16'($urandom));
        random_frames(125);

        settle();
        if (sb.errors == 0 && sb.expected_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
